// ===== design/vcms_pkg.sv =====
`default_nettype none

package vcms_pkg;

  // Largest dimension in use along any axis.
  localparam int MAX_DIM  = 256;
  localparam int LOG_DIM  = $clog2(MAX_DIM);
  localparam int POS_W    = $clog2(MAX_DIM + 1);

  // Field and register widths.
  localparam int DIM_W    = 9;
  localparam int VOX_W    = 16;
  localparam int SIZE_W   = 24;
  localparam int SCALE_W  = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int TOT_W    = 64;
  localparam int CEN_OUT_W = 32;

  // Accumulator widths: a full volume of extreme voxels must not wrap.
  localparam int RAW_W    = VOX_W + 3 * LOG_DIM;
  localparam int WGT_W    = RAW_W + LOG_DIM + 1;
  localparam int WP_W     = POS_W + 1 + VOX_W;
  localparam int CNT_W    = 3 * LOG_DIM + 1;

  // Shared multiplier: operand A is taken in two chunks, operand B at once.
  localparam int SIZE10_W = SIZE_W + 4;
  localparam int MUL_A_W  = WGT_W - 1;
  localparam int MUL_CH_W = MUL_A_W / 2;
  localparam int MUL_B_W  = SCALE_W;
  localparam int PP_W     = MUL_CH_W + MUL_B_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // Shared restoring divider, one quotient bit per cycle.
  localparam int DVD_W    = MUL_A_W + SIZE10_W;
  localparam int STEP_W   = $clog2(DVD_W);

  // Center post-processing: clamp to 2^40, subtract 1.0 in Q16, clamp to 32 bits.
  localparam int CEN_W    = 43;
  localparam logic [CEN_W-1:0] CEN_LIM  = CEN_W'(1) << 40;
  localparam logic [CEN_W-1:0] FRAC_ONE = CEN_W'(65536);
  localparam logic [CEN_W-1:0] CEN_MAX  = {{(CEN_W-31){1'b0}}, {31{1'b1}}};
  localparam logic [CEN_W-1:0] CEN_MIN  = {{(CEN_W-31){1'b1}}, {31{1'b0}}};

  // Saturation caps for the 64-bit results.
  localparam logic [PROD_W-1:0] POS_CAP64 = PROD_W'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [PROD_W-1:0] NEG_CAP64 = PROD_W'(64'h8000_0000_0000_0000);

  typedef enum logic [IDX_W-1:0] {
    REG_DIM_X,
    REG_DIM_Y,
    REG_DIM_Z,
    REG_FORMAT,
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_SCALE
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]          dim_x;
    logic [DIM_W-1:0]          dim_y;
    logic [DIM_W-1:0]          dim_z;
    logic                      fmt;
    logic [SIZE_W-1:0]         size_x;
    logic [SIZE_W-1:0]         size_y;
    logic [SIZE_W-1:0]         size_z;
    logic signed [SCALE_W-1:0] scale;
  } cfg_t;

  typedef enum logic [3:0] {
    S_ACC,
    S_DXY,
    S_DXYZ,
    S_TLO,
    S_THI,
    S_TOT,
    S_MDIV,
    S_MEAN,
    S_CLO,
    S_CHI,
    S_CLD,
    S_CDIV,
    S_CRES,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_LO,
    MOP_HI
  } mul_op_t;

  typedef enum logic [2:0] {
    OPD_DXY,
    OPD_DXYZ,
    OPD_TOT,
    OPD_WX,
    OPD_WY,
    OPD_WZ
  } opnd_t;

  typedef enum logic {
    DIV_CNT,
    DIV_RAW
  } dsel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_MEAN,
    RES_CX,
    RES_CY,
    RES_CZ
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    acc_en;
    mul_op_t mul_op;
    opnd_t   opnd;
    logic    cnt_ld;
    logic    tot_ld;
    logic    div_ld;
    dsel_t   div_sel;
    logic    div_step;
    res_t    res_sel;
    logic    emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic zero;
    logic out_blocked;
  } sts_t;

  // A dimension of zero acts as one, any value above the maximum as the maximum.
  function automatic logic [POS_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [POS_W-1:0] r;
    if (d == '0) begin
      r = POS_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = POS_W'(MAX_DIM);
    end else begin
      r = POS_W'(d);
    end
    return r;
  endfunction

  // Signed 64-bit value from sign and magnitude, saturated.
  function automatic logic [TOT_W-1:0] sat64(input logic neg, input logic [PROD_W-1:0] mag);
    logic [PROD_W-1:0] cap;
    logic [TOT_W-1:0]  m;
    cap = neg ? NEG_CAP64 : POS_CAP64;
    m = (mag > cap) ? cap[TOT_W-1:0] : mag[TOT_W-1:0];
    return neg ? (~m + TOT_W'(1)) : m;
  endfunction

  // Center quotient to Q15.16 millimeters minus one, saturated at both steps.
  function automatic logic [CEN_OUT_W-1:0] center_fix(input logic neg,
                                                       input logic [DVD_W-1:0] mag);
    logic [DVD_W-1:0] cap;
    logic [CEN_W-1:0] m;
    logic [CEN_W-1:0] q;
    logic [CEN_W-1:0] d;
    logic [CEN_OUT_W-1:0] r;
    cap = neg ? (DVD_W'(CEN_LIM) + DVD_W'(1)) : DVD_W'(CEN_LIM);
    m = (mag > cap) ? cap[CEN_W-1:0] : mag[CEN_W-1:0];
    q = neg ? (~m + CEN_W'(1)) : m;
    d = q - FRAC_ONE;
    if ($signed(d) > $signed(CEN_MAX)) begin
      r = CEN_MAX[CEN_OUT_W-1:0];
    end else if ($signed(d) < $signed(CEN_MIN)) begin
      r = CEN_MIN[CEN_OUT_W-1:0];
    end else begin
      r = d[CEN_OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/vcms_cfg.sv =====
`default_nettype none

module vcms_cfg
  import vcms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; every index in the map is a register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DIM_X:  cfg_nxt.dim_x  = cfg_wdata[DIM_W-1:0];
        REG_DIM_Y:  cfg_nxt.dim_y  = cfg_wdata[DIM_W-1:0];
        REG_DIM_Z:  cfg_nxt.dim_z  = cfg_wdata[DIM_W-1:0];
        REG_FORMAT: cfg_nxt.fmt    = cfg_wdata[0];
        REG_SIZE_X: cfg_nxt.size_x = cfg_wdata[SIZE_W-1:0];
        REG_SIZE_Y: cfg_nxt.size_y = cfg_wdata[SIZE_W-1:0];
        REG_SIZE_Z: cfg_nxt.size_z = cfg_wdata[SIZE_W-1:0];
        REG_SCALE:  cfg_nxt.scale  = $signed(cfg_wdata[SCALE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x  <= DIM_W'(256);
      cfg_r.dim_y  <= DIM_W'(256);
      cfg_r.dim_z  <= DIM_W'(256);
      cfg_r.fmt    <= 1'b1;
      cfg_r.size_x <= SIZE_W'(65536);
      cfg_r.size_y <= SIZE_W'(65536);
      cfg_r.size_z <= SIZE_W'(65536);
      cfg_r.scale  <= SCALE_W'(65536);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/vcms_ctrl.sv =====
`default_nettype none

module vcms_ctrl
  import vcms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      st,
  output cmd_t      cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  axis_t             axis_r, axis_nxt;
  opnd_t             ax_opnd;
  res_t              ax_res;

  // Per-axis operand and result selection.
  always_comb begin
    case (axis_r)
      AX_X: begin
        ax_opnd = OPD_WX;
        ax_res  = RES_CX;
      end
      AX_Y: begin
        ax_opnd = OPD_WY;
        ax_res  = RES_CY;
      end
      AX_Z: begin
        ax_opnd = OPD_WZ;
        ax_res  = RES_CZ;
      end
      default: begin
        ax_opnd = OPD_WX;
        ax_res  = RES_NONE;
      end
    endcase
  end

  // Next state, division step count and axis.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    case (state_r)
      S_ACC: begin
        if (in_valid && st.last) begin
          state_nxt = S_DXY;
        end
      end
      S_DXY:  state_nxt = S_DXYZ;
      S_DXYZ: state_nxt = S_TLO;
      S_TLO:  state_nxt = S_THI;
      S_THI:  state_nxt = S_TOT;
      S_TOT: begin
        step_nxt  = '0;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        axis_nxt  = AX_X;
        state_nxt = st.zero ? S_DONE : S_CLO;
      end
      S_CLO: state_nxt = S_CHI;
      S_CHI: state_nxt = S_CLD;
      S_CLD: begin
        step_nxt  = '0;
        state_nxt = S_CDIV;
      end
      S_CDIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          state_nxt = S_CRES;
        end
      end
      S_CRES: begin
        case (axis_r)
          AX_X: begin
            axis_nxt  = AX_Y;
            state_nxt = S_CLO;
          end
          AX_Y: begin
            axis_nxt  = AX_Z;
            state_nxt = S_CLO;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!st.out_blocked) begin
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  // Commands per state.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_ACC);
    case (state_r)
      S_ACC: cmd.acc_en = in_valid;
      S_DXY: begin
        cmd.mul_op = MOP_LO;
        cmd.opnd   = OPD_DXY;
      end
      S_DXYZ: begin
        cmd.mul_op = MOP_LO;
        cmd.opnd   = OPD_DXYZ;
      end
      S_TLO: begin
        cmd.cnt_ld = 1'b1;
        cmd.mul_op = MOP_LO;
        cmd.opnd   = OPD_TOT;
      end
      S_THI: begin
        cmd.mul_op = MOP_HI;
        cmd.opnd   = OPD_TOT;
      end
      S_TOT: begin
        cmd.tot_ld  = 1'b1;
        cmd.div_ld  = 1'b1;
        cmd.div_sel = DIV_CNT;
      end
      S_MDIV: cmd.div_step = 1'b1;
      S_MEAN: cmd.res_sel  = RES_MEAN;
      S_CLO: begin
        cmd.mul_op = MOP_LO;
        cmd.opnd   = ax_opnd;
      end
      S_CHI: begin
        cmd.mul_op = MOP_HI;
        cmd.opnd   = ax_opnd;
      end
      S_CLD: begin
        cmd.div_ld  = 1'b1;
        cmd.div_sel = DIV_RAW;
      end
      S_CDIV: cmd.div_step = 1'b1;
      S_CRES: cmd.res_sel  = ax_res;
      S_DONE: cmd.emit     = !st.out_blocked;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      step_r  <= '0;
      axis_r  <= AX_X;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // The voxel that closes a volume stops the input until the result is out.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_en && st.last) |=> in_stall)
    else $error("input not stalled after the last voxel of a volume");

endmodule

`default_nettype wire

// ===== design/vcms_dp.sv =====
`default_nettype none

module vcms_dp
  import vcms_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  cfg_t                          cfg,
  input  cmd_t                          cmd,
  output sts_t                          st,
  input  wire logic signed [VOX_W-1:0]  in_voxel,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [TOT_W-1:0]       out_total_scaled,
  output logic signed [TOT_W-1:0]       out_mean_scaled,
  output logic signed [CEN_OUT_W-1:0]   out_center_x_mm,
  output logic signed [CEN_OUT_W-1:0]   out_center_y_mm,
  output logic signed [CEN_OUT_W-1:0]   out_center_z_mm,
  output logic                          out_zero_total
);

  logic [POS_W-1:0] dx, dy, dz;
  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic signed [RAW_W-1:0] raw_r, raw_nxt;
  logic signed [WGT_W-1:0] wx_r, wy_r, wz_r, wx_nxt, wy_nxt, wz_nxt;
  logic signed [VOX_W-1:0] vox_v;
  logic signed [WP_W-1:0]  wp_x, wp_y, wp_z;

  logic [RAW_W-1:0]    raw_mag;
  logic [WGT_W-1:0]    wx_mag, wy_mag, wz_mag;
  logic [MUL_B_W-1:0]  scale_mag;
  logic [SIZE10_W-1:0] sz10_x, sz10_y, sz10_z;
  logic                neg_tot;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_CH_W-1:0] mul_ch;
  logic [PP_W-1:0]     pp;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [CNT_W-1:0]    cnt_r;

  logic [DVD_W-1:0]    dq_r, dq_nxt;
  logic [RAW_W-1:0]    rem_r, rem_nxt;
  logic [RAW_W-1:0]    dvs_r, dvs_nxt;
  logic [RAW_W:0]      rem_sh;

  logic [TOT_W-1:0]     res_tot_r, res_mean_r;
  logic [CEN_OUT_W-1:0] res_cx_r, res_cy_r, res_cz_r;
  logic                 out_valid_r;
  logic                 zero;

  // Effective dimensions and end-of-volume detection.
  assign dx = clamp_dim(cfg.dim_x);
  assign dy = clamp_dim(cfg.dim_y);
  assign dz = clamp_dim(cfg.dim_z);

  assign zero = (raw_r == '0);
  assign st = '{last:        (pos_x_r >= dx) && (pos_y_r >= dy) && (pos_z_r >= dz),
                zero:        zero,
                out_blocked: out_valid_r && out_stall};

  // Voxel decode and position-weighted products.
  always_comb begin
    if (cfg.fmt) begin
      vox_v = in_voxel;
    end else begin
      vox_v = $signed({{(VOX_W-8){1'b0}}, in_voxel[7:0]});
    end
    wp_x = $signed({1'b0, pos_x_r}) * vox_v;
    wp_y = $signed({1'b0, pos_y_r}) * vox_v;
    wp_z = $signed({1'b0, pos_z_r}) * vox_v;
  end

  // Running sums; cleared when the result leaves.
  always_comb begin
    raw_nxt = raw_r;
    wx_nxt  = wx_r;
    wy_nxt  = wy_r;
    wz_nxt  = wz_r;
    if (cmd.emit) begin
      raw_nxt = '0;
      wx_nxt  = '0;
      wy_nxt  = '0;
      wz_nxt  = '0;
    end else if (cmd.acc_en) begin
      raw_nxt = raw_r + {{(RAW_W-VOX_W){vox_v[VOX_W-1]}}, vox_v};
      wx_nxt  = wx_r + {{(WGT_W-WP_W){wp_x[WP_W-1]}}, wp_x};
      wy_nxt  = wy_r + {{(WGT_W-WP_W){wp_y[WP_W-1]}}, wp_y};
      wz_nxt  = wz_r + {{(WGT_W-WP_W){wp_z[WP_W-1]}}, wp_z};
    end
  end

  // Raster position counters, x fastest.
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (cmd.acc_en) begin
      if (pos_x_r < dx) begin
        pos_x_nxt = pos_x_r + POS_W'(1);
      end else begin
        pos_x_nxt = POS_W'(1);
        if (pos_y_r < dy) begin
          pos_y_nxt = pos_y_r + POS_W'(1);
        end else begin
          pos_y_nxt = POS_W'(1);
          if (pos_z_r < dz) begin
            pos_z_nxt = pos_z_r + POS_W'(1);
          end else begin
            pos_z_nxt = POS_W'(1);
          end
        end
      end
    end
  end

  // Magnitudes and signs for the end-of-volume arithmetic.
  always_comb begin
    raw_mag   = raw_r[RAW_W-1] ? (~raw_r + RAW_W'(1)) : raw_r;
    wx_mag    = wx_r[WGT_W-1] ? (~wx_r + WGT_W'(1)) : wx_r;
    wy_mag    = wy_r[WGT_W-1] ? (~wy_r + WGT_W'(1)) : wy_r;
    wz_mag    = wz_r[WGT_W-1] ? (~wz_r + WGT_W'(1)) : wz_r;
    scale_mag = cfg.scale[SCALE_W-1] ? (~cfg.scale + SCALE_W'(1)) : cfg.scale;
    sz10_x    = {1'b0, cfg.size_x, 3'b000} + {2'b00, cfg.size_x, 1'b0};
    sz10_y    = {1'b0, cfg.size_y, 3'b000} + {2'b00, cfg.size_y, 1'b0};
    sz10_z    = {1'b0, cfg.size_z, 3'b000} + {2'b00, cfg.size_z, 1'b0};
    neg_tot   = raw_r[RAW_W-1] ^ cfg.scale[SCALE_W-1];
  end

  // Shared multiplier: one chunk of A times B per cycle.
  always_comb begin
    case (cmd.opnd)
      OPD_DXY: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'(dy);
      end
      OPD_DXYZ: begin
        mul_a = MUL_A_W'(prod_r[MUL_CH_W-1:0]);
        mul_b = MUL_B_W'(dz);
      end
      OPD_TOT: begin
        mul_a = MUL_A_W'(raw_mag);
        mul_b = scale_mag;
      end
      OPD_WX: begin
        mul_a = wx_mag[MUL_A_W-1:0];
        mul_b = MUL_B_W'(sz10_x);
      end
      OPD_WY: begin
        mul_a = wy_mag[MUL_A_W-1:0];
        mul_b = MUL_B_W'(sz10_y);
      end
      OPD_WZ: begin
        mul_a = wz_mag[MUL_A_W-1:0];
        mul_b = MUL_B_W'(sz10_z);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_ch = (cmd.mul_op == MOP_HI) ? mul_a[MUL_A_W-1:MUL_CH_W] : mul_a[MUL_CH_W-1:0];
    pp = PP_W'(mul_ch) * PP_W'(mul_b);
    case (cmd.mul_op)
      MOP_LO:  prod_nxt = PROD_W'(pp);
      MOP_HI:  prod_nxt = prod_r + (PROD_W'(pp) << MUL_CH_W);
      default: prod_nxt = prod_r;
    endcase
  end

  // Restoring divider: quotient bits shift in where dividend bits leave.
  always_comb begin
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    rem_sh  = {rem_r, dq_r[DVD_W-1]};
    if (cmd.div_ld) begin
      dq_nxt  = prod_r[DVD_W-1:0];
      rem_nxt = '0;
      dvs_nxt = (cmd.div_sel == DIV_CNT) ? RAW_W'(cnt_r) : raw_mag;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = RAW_W'(rem_sh - {1'b0, dvs_r});
        dq_nxt  = {dq_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[RAW_W-1:0];
        dq_nxt  = {dq_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Control state: positions, sums and the output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= POS_W'(1);
      pos_y_r     <= POS_W'(1);
      pos_z_r     <= POS_W'(1);
      raw_r       <= '0;
      wx_r        <= '0;
      wy_r        <= '0;
      wz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      raw_r   <= raw_nxt;
      wx_r    <= wx_nxt;
      wy_r    <= wy_nxt;
      wz_r    <= wz_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Arithmetic registers, staged results and the output register.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    if (cmd.cnt_ld) begin
      cnt_r <= prod_r[CNT_W-1:0];
    end
    if (cmd.tot_ld) begin
      res_tot_r <= sat64(neg_tot, prod_r);
    end
    case (cmd.res_sel)
      RES_MEAN: res_mean_r <= sat64(neg_tot, PROD_W'(dq_r));
      RES_CX:   res_cx_r <= center_fix(wx_r[WGT_W-1] ^ raw_r[RAW_W-1], dq_r);
      RES_CY:   res_cy_r <= center_fix(wy_r[WGT_W-1] ^ raw_r[RAW_W-1], dq_r);
      RES_CZ:   res_cz_r <= center_fix(wz_r[WGT_W-1] ^ raw_r[RAW_W-1], dq_r);
      default: begin
      end
    endcase
    if (cmd.emit) begin
      out_total_scaled <= res_tot_r;
      out_mean_scaled  <= res_mean_r;
      out_center_x_mm  <= zero ? '0 : res_cx_r;
      out_center_y_mm  <= zero ? '0 : res_cy_r;
      out_center_z_mm  <= zero ? '0 : res_cz_r;
      out_zero_total   <= zero;
    end
  end

  assign out_valid = out_valid_r;

  // Sums start from zero for the next volume once a result leaves.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (raw_r == '0) && (wx_r == '0) && (wy_r == '0) && (wz_r == '0))
    else $error("sums not cleared after a result was emitted");

  // The divider never runs against a zero divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (dvs_r != '0))
    else $error("division step with a zero divisor");

  // Positions stay within one and the largest dimension.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pos_x_r >= POS_W'(1)) && (pos_x_r <= POS_W'(MAX_DIM)) &&
    (pos_y_r >= POS_W'(1)) && (pos_y_r <= POS_W'(MAX_DIM)) &&
    (pos_z_r >= POS_W'(1)) && (pos_z_r <= POS_W'(MAX_DIM)))
    else $error("voxel position out of range");

  // A new result is loaded only into a free output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit)
    else $error("result emitted over a stalled output");

endmodule

`default_nettype wire

// ===== design/volume_center_of_mass_stats.sv =====
// Channel   Ports                                   Direction  Transfer
// config    cfg_we, cfg_index, cfg_wdata            in         write when cfg_we is high
// voxel     in_valid, in_stall, in_voxel            in         valid high and stall low
// result    out_valid, out_stall, out_* fields      out        valid high and stall low
//
// Voxels are taken one per cycle while a volume is being summed.
// The voxel that closes a volume stalls the input until its result is emitted; with a
// zero total the centers are skipped. A shared 24x32 multiplier runs two-chunk passes and
// a shared restoring divider, one quotient bit per cycle, for the mean and each center.
// A waiting result does not stop summing; a stalled output holds the block only when
// the next result is ready. Reset is synchronous, active low, with no clearing pass.
`default_nettype none

module volume_center_of_mass_stats
  import vcms_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [VOX_W-1:0]  in_voxel,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [TOT_W-1:0]       out_total_scaled,
  output logic signed [TOT_W-1:0]       out_mean_scaled,
  output logic signed [CEN_OUT_W-1:0]   out_center_x_mm,
  output logic signed [CEN_OUT_W-1:0]   out_center_y_mm,
  output logic signed [CEN_OUT_W-1:0]   out_center_z_mm,
  output logic                          out_zero_total
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t st;

  vcms_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vcms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  vcms_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .st               (st),
    .in_voxel         (in_voxel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_scaled (out_total_scaled),
    .out_mean_scaled  (out_mean_scaled),
    .out_center_x_mm  (out_center_x_mm),
    .out_center_y_mm  (out_center_y_mm),
    .out_center_z_mm  (out_center_z_mm),
    .out_zero_total   (out_zero_total)
  );

endmodule

`default_nettype wire

// ===== tb/tb_volume_center_of_mass_stats.sv =====
`timescale 1ns / 100ps

module tb_volume_center_of_mass_stats;
  import vcms_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int VOXEL_TARGET = 550;

  typedef struct packed {
    logic [63:0] total;
    logic [63:0] mean;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic        zero;
  } com_result_t;

  // Tracks one volume's sums and positions and predicts the statistics it yields.
  class volume_stats_tracker;
    logic [8:0]  dim_x, dim_y, dim_z;
    bit          fmt;
    logic [23:0] size_x, size_y, size_z;
    logic [31:0] scale;
    int          pos_x, pos_y, pos_z;
    longint      raw_total, wsum_x, wsum_y, wsum_z;
    com_result_t expected_stats[$];
    int          fail_count;

    function new();
      dim_x = 9'd256;
      dim_y = 9'd256;
      dim_z = 9'd256;
      fmt = 1'b1;
      size_x = 24'd65536;
      size_y = 24'd65536;
      size_z = 24'd65536;
      scale = 32'd65536;
      pos_x = 1;
      pos_y = 1;
      pos_z = 1;
      raw_total = 0;
      wsum_x = 0;
      wsum_y = 0;
      wsum_z = 0;
      fail_count = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_DIM_X:  dim_x = val[8:0];
        REG_DIM_Y:  dim_y = val[8:0];
        REG_DIM_Z:  dim_z = val[8:0];
        REG_FORMAT: fmt = val[0];
        REG_SIZE_X: size_x = val[23:0];
        REG_SIZE_Y: size_y = val[23:0];
        REG_SIZE_Z: size_z = val[23:0];
        REG_SCALE:  scale = val;
        default: ;
      endcase
    endfunction

    // A zero dimension counts as one; anything past the maximum counts as the maximum.
    function int clamp_axis(logic [8:0] d);
      if (d == 9'd0) return 1;
      if (int'(d) > MAX_DIM) return MAX_DIM;
      return int'(d);
    endfunction

    function logic [127:0] mag128(longint v);
      if (v < 0) return 128'(-v);
      return 128'(v);
    endfunction

    // Applies a sign to a magnitude, clamped to [-(lim+1), lim].
    function logic [63:0] saturate(bit neg, logic [127:0] mag, logic [127:0] lim);
      logic [127:0] cap;
      logic [127:0] m;
      logic [127:0] neg_m;
      cap = neg ? lim + 128'd1 : lim;
      m = (mag > cap) ? cap : mag;
      neg_m = -m;
      return neg ? neg_m[63:0] : m[63:0];
    endfunction

    // Center in mm (Q15.16) minus one, clamped first to 2^40 and then to 32 bits.
    function logic [31:0] center_mm(longint wsum, logic [23:0] size_cm);
      bit           neg;
      logic [127:0] quot;
      longint       q;
      neg = (wsum < 0) != (raw_total < 0);
      quot = mag128(wsum) * (128'(size_cm) * 128'd10) / mag128(raw_total);
      q = longint'(saturate(neg, quot, 128'd1 << 40)) - 64'sd65536;
      if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -64'sd2147483648) return 32'h8000_0000;
      return 32'(q);
    endfunction

    function void note_voxel(logic [15:0] raw);
      int           dx, dy, dz;
      longint       v;
      longint       sc;
      logic [127:0] prod;
      bit           neg;
      com_result_t  r;
      dx = clamp_axis(dim_x);
      dy = clamp_axis(dim_y);
      dz = clamp_axis(dim_z);
      if (fmt) begin
        v = longint'($signed(raw));
      end else begin
        v = longint'(raw[7:0]);
      end
      raw_total += v;
      wsum_x += longint'(pos_x) * v;
      wsum_y += longint'(pos_y) * v;
      wsum_z += longint'(pos_z) * v;

      // Raster walk, x fastest; only the last voxel of the volume yields a result.
      if (pos_x < dx) begin
        pos_x++;
        return;
      end
      pos_x = 1;
      if (pos_y < dy) begin
        pos_y++;
        return;
      end
      pos_y = 1;
      if (pos_z < dz) begin
        pos_z++;
        return;
      end
      pos_z = 1;

      sc = longint'($signed(scale));
      neg = (raw_total < 0) != (sc < 0);
      prod = mag128(raw_total) * mag128(sc);
      r.total = saturate(neg, prod, 128'h7FFF_FFFF_FFFF_FFFF);
      r.mean = saturate(neg, prod / 128'(dx * dy * dz), 128'h7FFF_FFFF_FFFF_FFFF);
      r.zero = (raw_total == 0);
      if (r.zero) begin
        r.cx = '0;
        r.cy = '0;
        r.cz = '0;
      end else begin
        r.cx = center_mm(wsum_x, size_x);
        r.cy = center_mm(wsum_y, size_y);
        r.cz = center_mm(wsum_z, size_z);
      end
      expected_stats.push_back(r);
      raw_total = 0;
      wsum_x = 0;
      wsum_y = 0;
      wsum_z = 0;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] stats mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
    endtask

    task check_stats(com_result_t got);
      com_result_t want;
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result", got.total, 64'd0);
        return;
      end
      want = expected_stats.pop_front();
      if (got.total !== want.total) report_mismatch("total_scaled", got.total, want.total);
      if (got.mean !== want.mean) report_mismatch("mean_scaled", got.mean, want.mean);
      if (got.cx !== want.cx) report_mismatch("center_x_mm", 64'(got.cx), 64'(want.cx));
      if (got.cy !== want.cy) report_mismatch("center_y_mm", 64'(got.cy), 64'(want.cy));
      if (got.cz !== want.cz) report_mismatch("center_z_mm", 64'(got.cz), 64'(want.cz));
      if (got.zero !== want.zero) report_mismatch("zero_total", 64'(got.zero), 64'(want.zero));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  reg_idx_t    cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_voxel;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_total_scaled;
  logic [63:0] out_mean_scaled;
  logic [31:0] out_center_x_mm;
  logic [31:0] out_center_y_mm;
  logic [31:0] out_center_z_mm;
  logic        out_zero_total;

  volume_stats_tracker stats;
  com_result_t         seen;
  logic [31:0]         cfg_val [8];
  bit   [7:0]          cfg_mask;
  int                  burst_left;
  int                  voxel_count;
  int                  cycle_count;
  bit                  hold_req;
  int                  rx_mode;
  int                  rx_left;
  int                  rx_tick;

  volume_center_of_mass_stats dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_voxel         (in_voxel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_scaled (out_total_scaled),
    .out_mean_scaled  (out_mean_scaled),
    .out_center_x_mm  (out_center_x_mm),
    .out_center_y_mm  (out_center_y_mm),
    .out_center_z_mm  (out_center_z_mm),
    .out_zero_total   (out_zero_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.total = out_total_scaled;
      seen.mean = out_mean_scaled;
      seen.cx = out_center_x_mm;
      seen.cy = out_center_y_mm;
      seen.cz = out_center_z_mm;
      seen.zero = out_zero_total;
      stats.check_stats(seen);
    end
  end

  // Result receiver: stall modes change every so often, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    rx_left = 0;
    rx_mode = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  // Writes the registers selected in cfg_mask; called at a falling edge.
  task automatic apply_cfg();
    for (int i = 0; i < 8; i++) begin
      if (cfg_mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= reg_idx_t'(i);
        cfg_wdata <= cfg_val[i];
        @(posedge clk);
        stats.write_reg(reg_idx_t'(i), cfg_val[i]);
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(input int dx, input int dy, input int dz, input bit fmt,
                         input logic [23:0] sx, input logic [23:0] sy,
                         input logic [23:0] sz, input logic [31:0] scale);
    cfg_val[REG_DIM_X] = 32'(dx);
    cfg_val[REG_DIM_Y] = 32'(dy);
    cfg_val[REG_DIM_Z] = 32'(dz);
    cfg_val[REG_FORMAT] = 32'(fmt);
    cfg_val[REG_SIZE_X] = 32'(sx);
    cfg_val[REG_SIZE_Y] = 32'(sy);
    cfg_val[REG_SIZE_Z] = 32'(sz);
    cfg_val[REG_SCALE] = scale;
    cfg_mask = 8'hFF;
    apply_cfg();
  endtask

  // Offers one voxel, waits for it to be taken, then maybe opens a gap.
  task automatic push_voxel(input logic [15:0] v);
    int gap;
    in_valid <= 1'b1;
    in_voxel <= v;
    do @(posedge clk); while (in_stall);
    stats.note_voxel(v);
    voxel_count++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Lets the block go idle so the registers can be rewritten.
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (stats.expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_voxel();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          4: return 16'h00FF;
          default: return 16'h0100;
        endcase
      end
      1: return 16'($urandom);
      default: return 16'($urandom_range(0, 200)) - 16'd100;
    endcase
  endfunction

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return 32'd256;
      2: return 32'($urandom_range(257, 511));
      3: return 32'd255;
      default: return 32'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFF_FFFF;
      2: return 32'd65536;
      default: return 32'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stats = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DIM_X;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_voxel = '0;
    hold_req = 1'b0;
    burst_left = 0;
    voxel_count = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opposite extremes in one row: the total comes out at minus one.
    set_cfg(2, 1, 1, 1'b1, 24'd65536, 24'd65536, 24'd65536, 32'd65536);
    push_voxel(16'h7FFF);
    push_voxel(16'h8000);
    settle();

    // Zero dimensions act as one; most negative scale; zero size; then a zero total.
    set_cfg(0, 0, 0, 1'b1, 24'd0, 24'hFF_FFFF, 24'd65536, 32'h8000_0000);
    push_voxel(16'h8000);
    push_voxel(16'h0000);
    settle();

    // Byte mode ignores the upper half of the voxel.
    set_cfg(3, 1, 1, 1'b0, 24'd65536, 24'd65536, 24'd65536, 32'h7FFF_FFFF);
    push_voxel(16'hFF80);
    push_voxel(16'h00FF);
    push_voxel(16'h7F01);
    settle();

    // Tiny total against large weighted sums drives the y center into saturation.
    set_cfg(1, 2, 2, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'd65536);
    push_voxel(16'h7FFF);
    push_voxel(16'h8002);
    push_voxel(16'h0001);
    push_voxel(16'hFFFF);
    settle();

    // Oversized row, then a shrink mid-volume: the next voxel closes the volume.
    set_cfg(511, 1, 1, 1'b1, 24'd65536, 24'd32768, 24'd131072, 32'd65536);
    push_voxel(16'd100);
    push_voxel(16'd200);
    push_voxel(16'd300);
    settle();
    set_cfg(2, 1, 1, 1'b1, 24'd65536, 24'd32768, 24'd131072, 32'd65536);
    push_voxel(16'd400);
    settle();

    // Nonzero voxels that cancel give a zero total, here with a negative scale.
    set_cfg(2, 1, 1, 1'b1, 24'd65536, 24'd65536, 24'd65536, 32'hFFFF_0000);
    push_voxel(16'd5);
    push_voxel(-16'd5);
    settle();

    // One full-length row walks x all the way to the maximum.
    set_cfg(256, 1, 1, 1'b1, rand_size(), rand_size(), rand_size(), rand_scale());
    repeat (256) push_voxel(rand_voxel());
    settle();

    // Receiver holds off while single-voxel volumes keep coming, so the block backs up.
    set_cfg(1, 1, 1, 1'b1, rand_size(), rand_size(), rand_size(), rand_scale());
    hold_req = 1'b1;
    repeat (16) push_voxel(rand_voxel());
    settle();

    // Random phases: a random subset of registers, then a run of random voxels.
    while (voxel_count < VOXEL_TARGET) begin
      cfg_mask = 8'($urandom);
      cfg_val[REG_DIM_X] = rand_dim();
      cfg_val[REG_DIM_Y] = rand_dim();
      cfg_val[REG_DIM_Z] = rand_dim();
      cfg_val[REG_FORMAT] = 32'($urandom_range(0, 1));
      cfg_val[REG_SIZE_X] = rand_size();
      cfg_val[REG_SIZE_Y] = rand_size();
      cfg_val[REG_SIZE_Z] = rand_size();
      cfg_val[REG_SCALE] = rand_scale();
      apply_cfg();
      @(negedge clk);
      repeat ($urandom_range(8, 40)) push_voxel(rand_voxel());
      settle();
    end

    if (stats.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/vcms_pkg.sv
design/vcms_cfg.sv
design/vcms_ctrl.sv
design/vcms_dp.sv
design/volume_center_of_mass_stats.sv
tb/tb_volume_center_of_mass_stats.sv
